/* rtl/core/bqd_pkg.sv */
`default_nettype none

package bqd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;

  localparam int STATE_WIDTH = 48;
  localparam int STATE_FRAC  = 44;
  localparam int TERM_WIDTH  = STATE_WIDTH - 1;
  localparam int ACC_WIDTH   = STATE_WIDTH + 3;

  localparam int NUM_COEFS = 5;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD_D1,
    ACC_ADD_D2,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    ACC2_HOLD,
    ACC2_LOAD,
    ACC2_SUB
  } acc2_op_t;

  typedef struct packed {
    logic      load_x;
    coef_sel_t coef_sel;
    logic      mul_y;
    acc_op_t   acc_op;
    acc2_op_t  acc2_op;
    logic      load_y;
    logic      load_d1;
    logic      load_d2;
    logic      load_out;
  } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/bqd_ctrl.sv */
`default_nettype none

module bqd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bqd_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_ACC0,
    ST_RND,
    ST_FB1,
    ST_FB2,
    ST_UPD,
    ST_PUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.coef_sel = bqd_pkg::COEF_B0;
    cmd.acc_op   = bqd_pkg::ACC_HOLD;
    cmd.acc2_op  = bqd_pkg::ACC2_HOLD;
    state_nxt    = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_x = in_valid;
        if (in_valid) begin
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd.coef_sel = bqd_pkg::COEF_B0;
        state_nxt    = ST_ACC0;
      end
      ST_ACC0: begin
        cmd.acc_op   = bqd_pkg::ACC_ADD_D1;
        cmd.coef_sel = bqd_pkg::COEF_B1;
        state_nxt    = ST_RND;
      end
      ST_RND: begin
        cmd.load_y   = 1'b1;
        cmd.acc_op   = bqd_pkg::ACC_ADD_D2;
        cmd.coef_sel = bqd_pkg::COEF_B2;
        state_nxt    = ST_FB1;
      end
      ST_FB1: begin
        cmd.acc2_op  = bqd_pkg::ACC2_LOAD;
        cmd.coef_sel = bqd_pkg::COEF_A1;
        cmd.mul_y    = 1'b1;
        state_nxt    = ST_FB2;
      end
      ST_FB2: begin
        cmd.acc_op   = bqd_pkg::ACC_SUB;
        cmd.coef_sel = bqd_pkg::COEF_A2;
        cmd.mul_y    = 1'b1;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        cmd.load_d1 = 1'b1;
        cmd.acc2_op = bqd_pkg::ACC2_SUB;
        state_nxt   = ST_PUT;
      end
      ST_PUT: begin
        cmd.load_d2  = 1'b1;
        cmd.load_out = slot_free;
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bqd_datapath.sv */
`default_nettype none

module bqd_datapath #(
  parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqd_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire bqd_pkg::dp_cmd_t                      cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        sample_in,
  output logic signed [SAMPLE_WIDTH-1:0]             sample_out,
  input  wire logic                                  cfg_we,
  input  wire logic [bqd_pkg::REG_IDX_W-1:0]         cfg_index,
  input  wire logic [COEF_WIDTH-1:0]                 cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_WIDTH;
  localparam int PW = SW + CW;
  localparam int TW = bqd_pkg::TERM_WIDTH;
  localparam int AW = bqd_pkg::ACC_WIDTH;
  localparam int DW = bqd_pkg::STATE_WIDTH;
  localparam int PROD_SHIFT = (SW - 1) + (CW - 2) - bqd_pkg::STATE_FRAC;
  localparam int OUT_SHIFT  = bqd_pkg::STATE_FRAC - (SW - 1);

  localparam logic signed [AW-1:0] RND_HALF = {{(AW-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);
  localparam logic signed [AW-1:0] Y_MAX    = ({{(AW-1){1'b0}}, 1'b1} << (SW - 1)) - 1;
  localparam logic signed [AW-1:0] Y_MIN    = -Y_MAX - 1;
  localparam logic signed [AW-1:0] D_MAX    = ({{(AW-1){1'b0}}, 1'b1} << (DW - 1)) - 1;
  localparam logic signed [AW-1:0] D_MIN    = -D_MAX - 1;
  localparam logic [CW-1:0]        B0_RESET = {{(CW-1){1'b0}}, 1'b1} << (CW - 2);

  logic signed [CW-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [SW-1:0] x_r;
  logic signed [SW-1:0] y_r;
  logic signed [SW-1:0] out_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc2_r;
  logic signed [DW-1:0] d1_r;
  logic signed [DW-1:0] d2_r;

  logic signed [CW-1:0] mul_a;
  logic signed [SW-1:0] mul_b;
  logic signed [TW-1:0] term;
  logic signed [AW-1:0] rnd_sum;
  logic signed [AW-1:0] rnd_shift;
  logic signed [AW-1:0] y_sat;
  logic signed [AW-1:0] acc_sat;
  logic signed [AW-1:0] acc2_sat;

  always_comb begin
    unique case (cmd.coef_sel)
      bqd_pkg::COEF_B0: mul_a = b0_r;
      bqd_pkg::COEF_B1: mul_a = b1_r;
      bqd_pkg::COEF_B2: mul_a = b2_r;
      bqd_pkg::COEF_A1: mul_a = a1_r;
      bqd_pkg::COEF_A2: mul_a = a2_r;
      default:          mul_a = b0_r;
    endcase
  end

  assign mul_b = cmd.mul_y ? y_r : x_r;

  generate
    if (PROD_SHIFT >= 0) begin : g_shr
      logic signed [PW-1:0] prod_shr;
      assign prod_shr = prod_r >>> PROD_SHIFT;
      assign term     = prod_shr[TW-1:0];
    end else begin : g_shl
      logic signed [TW-1:0] prod_ext;
      assign prod_ext = TW'(prod_r);
      assign term     = prod_ext <<< (-PROD_SHIFT);
    end
  endgenerate

  assign rnd_sum   = acc_r + RND_HALF;
  assign rnd_shift = rnd_sum >>> OUT_SHIFT;
  assign y_sat     = (rnd_shift > Y_MAX) ? Y_MAX :
                     (rnd_shift < Y_MIN) ? Y_MIN : rnd_shift;
  assign acc_sat   = (acc_r > D_MAX) ? D_MAX :
                     (acc_r < D_MIN) ? D_MIN : acc_r;
  assign acc2_sat  = (acc2_r > D_MAX) ? D_MAX :
                     (acc2_r < D_MIN) ? D_MIN : acc2_r;

  assign sample_out = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bqd_pkg::COEF_B0: b0_r <= cfg_data;
          bqd_pkg::COEF_B1: b1_r <= cfg_data;
          bqd_pkg::COEF_B2: b2_r <= cfg_data;
          bqd_pkg::COEF_A1: a1_r <= cfg_data;
          bqd_pkg::COEF_A2: a2_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_d1) begin
        d1_r <= acc_sat[DW-1:0];
      end
      if (cmd.load_d2) begin
        d2_r <= acc2_sat[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load_x) begin
      x_r <= sample_in;
    end
    if (cmd.load_y) begin
      y_r <= y_sat[SW-1:0];
    end
    if (cmd.load_out) begin
      out_r <= y_r;
    end
    unique case (cmd.acc_op)
      bqd_pkg::ACC_HOLD:   acc_r <= acc_r;
      bqd_pkg::ACC_ADD_D1: acc_r <= AW'(d1_r) + AW'(term);
      bqd_pkg::ACC_ADD_D2: acc_r <= AW'(d2_r) + AW'(term);
      bqd_pkg::ACC_SUB:    acc_r <= acc_r - AW'(term);
      default:             acc_r <= acc_r;
    endcase
    unique case (cmd.acc2_op)
      bqd_pkg::ACC2_HOLD: acc2_r <= acc2_r;
      bqd_pkg::ACC2_LOAD: acc2_r <= AW'(term);
      bqd_pkg::ACC2_SUB:  acc2_r <= acc2_r - AW'(term);
      default:            acc2_r <= acc2_r;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/biquad_tdf2_filter.sv */
// A new sample is accepted only in the idle state, after the previous result
// has been loaded into the output register; the single shared multiplier forms
// the five coefficient products in turn, and a result still waiting stalls it.
// Configuration writes are taken in any cycle (cfg_ready is always high).
// Reset (rst_n low, synchronous) clears both delay words and restores the
// coefficients to b0 = 1.0 and b1 = b2 = a1 = a2 = 0.
`default_nettype none

module biquad_tdf2_filter #(
  parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = bqd_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_sample_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]           out_sample_out,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bqd_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire logic [COEF_WIDTH-1:0]               cfg_data
);

  bqd_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  bqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bqd_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (in_sample_in),
    .sample_out (out_sample_out),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = bqd_pkg::SAMPLE_WIDTH_DEF;
  localparam int CW = bqd_pkg::COEF_WIDTH_DEF;
  localparam int IW = bqd_pkg::REG_IDX_W;
  localparam int NC = bqd_pkg::NUM_COEFS;
  localparam int PROD_SHIFT = (SW - 1) + (CW - 2) - bqd_pkg::STATE_FRAC;
  localparam int OUT_SHIFT = bqd_pkg::STATE_FRAC - (SW - 1);
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LIMIT = 50;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 122;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] CONE = {2'b01, {(CW-2){1'b0}}};
  localparam logic [CW-1:0] CMONE = {2'b11, {(CW-2){1'b0}}};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [SW-1:0] in_sample_in;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [SW-1:0] out_sample_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IW-1:0]        cfg_index;
  logic [CW-1:0]        cfg_data;

  logic signed [CW-1:0] coef_q [NC];
  longint               dly1;
  longint               dly2;
  logic signed [SW-1:0] expected_y [$];

  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          tx_throttle;
  bit          rx_throttle;

  biquad_tdf2_filter #(
    .SAMPLE_WIDTH(SW),
    .COEF_WIDTH  (CW)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint scaled_product(logic signed [CW-1:0] c, longint s);
    longint cs;
    cs = c;
    return (cs * s) >>> PROD_SHIFT;
  endfunction

  function automatic void reset_filter_state();
    coef_q[bqd_pkg::COEF_B0] = CONE;
    coef_q[bqd_pkg::COEF_B1] = '0;
    coef_q[bqd_pkg::COEF_B2] = '0;
    coef_q[bqd_pkg::COEF_A1] = '0;
    coef_q[bqd_pkg::COEF_A2] = '0;
    dly1 = 0;
    dly2 = 0;
  endfunction

  function automatic logic signed [SW-1:0] filter_sample(logic signed [SW-1:0] x);
    longint xs;
    longint acc;
    longint y;
    longint n1;
    longint n2;
    xs = x;
    acc = scaled_product(coef_q[bqd_pkg::COEF_B0], xs) + dly1;
    y = clamp((acc + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT, SW);
    n1 = scaled_product(coef_q[bqd_pkg::COEF_B1], xs) -
         scaled_product(coef_q[bqd_pkg::COEF_A1], y) + dly2;
    n2 = scaled_product(coef_q[bqd_pkg::COEF_B2], xs) -
         scaled_product(coef_q[bqd_pkg::COEF_A2], y);
    dly1 = clamp(n1, bqd_pkg::STATE_WIDTH);
    dly2 = clamp(n2, bqd_pkg::STATE_WIDTH);
    return y[SW-1:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 9);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [SW-1:0] random_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return SW'($urandom);
    if (r == 7) return ($urandom_range(0, 1) != 0) ? SMAX : SMIN;
    return SW'(int'($urandom_range(0, 511)) - 256);
  endfunction

  function automatic logic [CW-1:0] random_coef(int kind);
    if (kind == 0) return CW'($urandom);
    if (kind == 1) return CW'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
    case ($urandom_range(0, 4))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3: return CONE;
      default: return CMONE;
    endcase
  endfunction

  task automatic send_sample(logic signed [SW-1:0] x);
    int unsigned gap;
    gap = (tx_throttle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= x;
    do @(posedge clk); while (!in_ready);
    expected_y = {expected_y, filter_sample(x)};
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_y.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(logic [IW-1:0] idx, logic [CW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NC) coef_q[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_unity_gain();
    send_sample(SMAX);
    send_sample(SMIN);
    send_sample('0);
    send_sample(SW'(1));
    send_sample(-SW'(1));
    send_sample({(SW/2){2'b01}});
    send_sample({(SW/2){2'b10}});
  endtask

  task automatic test_saturation();
    drain();
    write_coef(bqd_pkg::COEF_B0, CMAX);
    write_coef(bqd_pkg::COEF_B1, CMIN);
    write_coef(bqd_pkg::COEF_B2, CMIN);
    write_coef(bqd_pkg::COEF_A1, CMAX);
    write_coef(bqd_pkg::COEF_A2, CMAX);
    send_sample(SMAX);
    send_sample(SMAX);
    send_sample(SMIN);
    send_sample(SMIN);
    send_sample(SMAX);
    send_sample('0);
    send_sample('0);
    drain();
    write_coef(bqd_pkg::COEF_B0, CMIN);
    write_coef(bqd_pkg::COEF_B1, CMAX);
    write_coef(bqd_pkg::COEF_B2, CMAX);
    write_coef(bqd_pkg::COEF_A1, CMIN);
    write_coef(bqd_pkg::COEF_A2, CMIN);
    send_sample(SMIN);
    send_sample(SMIN);
    send_sample(SMAX);
    send_sample('0);
    send_sample('0);
  endtask

  task automatic test_ignored_index();
    drain();
    write_coef(bqd_pkg::COEF_B0, CMONE);
    for (int i = NC; i < (1 << IW); i++) begin
      write_coef(IW'(i), CW'($urandom));
    end
    repeat (4) send_sample(random_sample());
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      tx_throttle = (p % 4) != 1;
      rx_throttle = (p % 4) != 2;
      for (int i = 0; i < NC; i++) begin
        write_coef(IW'(i), random_coef(p % 3));
      end
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    reset_filter_state();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_unity_gain();
    test_saturation();
    test_ignored_index();
    test_random_phases();
    drain();
    if (expected_y.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_throttle && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_y.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   out_sample_out);
        end
      end else begin
        if (out_sample_out !== expected_y[0]) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                     expected_y[0], out_sample_out);
          end
        end
        void'(expected_y.pop_front());
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
